// ----- hdl/bbgt_pkg.sv -----
package bbgt_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	// configuration register width and index codes
	localparam int SIZE_W = 12;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// raster counters and block coordinates
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int BX_W  = COL_W - 1;
	localparam int BY_W  = ROW_W - 1;
	localparam int HALF_W = SIZE_W - 1;

	// line store of even-row pair sums
	localparam int LS_DEPTH = MAX_WIDTH / 2;
	localparam int LS_AW    = $clog2(LS_DEPTH);

	localparam int SAMPLE_W = 8;
	localparam int SUM_W    = SAMPLE_W + 1;
	localparam int TOTAL_W  = SAMPLE_W + 2;
	localparam int PROD_W   = BX_W + HALF_W;
	localparam int IDX_W    = 20;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [LS_AW-1:0] addr;
		logic [SUM_W-1:0] wdata;
	} ls_req_t;

endpackage

// ----- hdl/bbgt_line_store.sv -----
module bbgt_line_store
	import bbgt_pkg::*;
(
	input  logic             clk,
	input  ls_req_t          req,
	output logic [SUM_W-1:0] rdata
);

	logic [SUM_W-1:0] mem [LS_DEPTH];
	logic [SUM_W-1:0] rdata_q;

	// single port: a write on even rows, a read on odd rows
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/bayer_bin2x2_gray_transpose_unit.sv -----
// Bayer 2x2 binning to gray with transposed pixel addressing. One raw byte is taken
// every clock cycle unless the output stalls; the rate is set by the single-port line
// store, which sees at most one access per byte (a write of the pair sum on even rows,
// a read on odd rows). A gray pixel passes through the result stage and the output
// register after the byte that completes its 2x2 block. Output holds back input only
// when both the result stage and the output register are full and the sink is
// stalling. The line store needs no clearing pass: every odd-row read hits an entry
// the even row above has written. frame_width and frame_height are clamped to 2..2048
// and must only be written while no transaction is in flight.
module bayer_bin2x2_gray_transpose_unit
	import bbgt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [7:0] raw_sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] gray_value, [27:8] pixel_index, zeros
	output logic                  m_axis_tlast    // frame_last
);

	logic [SIZE_W-1:0] frame_width_q, frame_height_q;
	logic [SIZE_W-1:0] w, h, w_even, h_even;
	logic [HALF_W-1:0] half_w, half_h;

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [SAMPLE_W-1:0] pair_q;
	logic [SIZE_W-1:0]   col_inc, row_inc;

	logic accept, in_block, produce;
	logic [SUM_W-1:0] pair_sum;
	logic [BX_W-1:0]  bx;
	logic [BY_W-1:0]  by;
	logic             is_last;
	ls_req_t          ls_req;
	logic [SUM_W-1:0] ls_rdata;

	logic             s1_valid_q;
	logic [SUM_W-1:0] sum_s1;
	logic [BX_W-1:0]  bx_s1;
	logic [BY_W-1:0]  by_s1;
	logic             last_s1;
	logic             out_free, s1_move;

	logic [TOTAL_W-1:0] total;
	logic [PROD_W-1:0]  index_full;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] gray_q;
	logic [IDX_W-1:0]    index_q;
	logic                last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_W'(640);
			frame_height_q <= SIZE_W'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < SIZE_W'(2))
			w = SIZE_W'(2);
		else if (frame_width_q > SIZE_W'(MAX_WIDTH))
			w = SIZE_W'(MAX_WIDTH);
		else
			w = frame_width_q;
		if (frame_height_q < SIZE_W'(2))
			h = SIZE_W'(2);
		else if (frame_height_q > SIZE_W'(MAX_HEIGHT))
			h = SIZE_W'(MAX_HEIGHT);
		else
			h = frame_height_q;
	end

	assign half_w = w[SIZE_W-1:1];
	assign half_h = h[SIZE_W-1:1];
	assign w_even = {half_w, 1'b0};
	assign h_even = {half_h, 1'b0};

	// result stage can move when the output register is empty or being drained
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s1_move       = s1_valid_q && out_free;

	assign col_inc  = SIZE_W'(col_q) + SIZE_W'(1);
	assign row_inc  = SIZE_W'(row_q) + SIZE_W'(1);
	assign in_block = (SIZE_W'(col_q) < w_even) && (SIZE_W'(row_q) < h_even);
	assign pair_sum = SUM_W'(pair_q) + SUM_W'(s_axis_tdata);
	assign bx       = col_q[COL_W-1:1];
	assign by       = row_q[ROW_W-1:1];
	assign produce  = accept && in_block && col_q[0] && row_q[0];
	assign is_last  = (HALF_W'(bx) + HALF_W'(1) == half_w) &&
	                  (HALF_W'(by) + HALF_W'(1) == half_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= w) begin
				col_q <= '0;
				row_q <= (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_block && !col_q[0])
			pair_q <= s_axis_tdata;
	end

	always_comb begin
		ls_req.en    = accept && in_block && col_q[0];
		ls_req.we    = !row_q[0];
		ls_req.addr  = LS_AW'(bx);
		ls_req.wdata = pair_sum;
	end

	bbgt_line_store u_line_store (
		.clk   (clk),
		.req   (ls_req),
		.rdata (ls_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (produce)
			s1_valid_q <= 1'b1;
		else if (s1_move)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			sum_s1  <= pair_sum;
			bx_s1   <= bx;
			by_s1   <= by;
			last_s1 <= is_last;
		end
	end

	// transposed index: block column times half-height plus block row
	assign total      = TOTAL_W'(ls_rdata) + TOTAL_W'(sum_s1);
	assign index_full = PROD_W'(bx_s1) * PROD_W'(half_h) + PROD_W'(by_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			gray_q  <= total[TOTAL_W-1:2];
			index_q <= index_full[IDX_W-1:0];
			last_q  <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - IDX_W - SAMPLE_W)'(0), index_q, gray_q};
	assign m_axis_tlast  = last_q;

	ap_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
		else $error("input stalled with a free slot in the pipeline");

	ap_result_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> s1_valid_q)
		else $error("completed block did not reach the result stage");

	ap_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_free) |=> out_valid_q)
		else $error("result stage did not move into the output register");

	ap_ls_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		ls_req.en |-> (accept && in_block))
		else $error("line store accessed without an accepted in-block byte");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
	import bbgt_pkg::*;

	localparam int LATENCY_WAIT = 8;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int RANDOM_ITEMS = 900;

	typedef struct packed {
		logic [SAMPLE_W-1:0] gray;
		logic [IDX_W-1:0]    index;
		logic                last;
	} gray_pixel_t;

	class binning_scoreboard;
		logic [SIZE_W-1:0] width_reg  = 640;
		logic [SIZE_W-1:0] height_reg = 480;
		int unsigned       col = 0;
		int unsigned       row = 0;
		logic [SUM_W-1:0]  pair = '0;
		bit [SUM_W-1:0]    half_row_sums [LS_DEPTH];
		gray_pixel_t       pixels_due [$];
		int                errors = 0;

		function int unsigned clamp_size(int unsigned v, int unsigned max_v);
			if (v < 2)
				return 2;
			if (v > max_v)
				return max_v;
			return v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
			case (idx)
				REG_FRAME_WIDTH: width_reg = v;
				REG_FRAME_HEIGHT: height_reg = v;
				default: ;
			endcase
		endfunction

		// bytes still to come before both counters are back at zero
		function int unsigned frame_left();
			int unsigned w, h, n;
			w = clamp_size(width_reg, MAX_WIDTH);
			h = clamp_size(height_reg, MAX_HEIGHT);
			n = (col + 1 >= w) ? 1 : w - col;
			if (row + 1 < h)
				n += (h - 1 - row) * w;
			return n;
		endfunction

		function void bin_sample(logic [SAMPLE_W-1:0] s);
			int unsigned        w, h, hw, hh, bx, by;
			logic [SUM_W-1:0]   sum;
			logic [TOTAL_W-1:0] total;
			gray_pixel_t        px;
			w  = clamp_size(width_reg, MAX_WIDTH);
			h  = clamp_size(height_reg, MAX_HEIGHT);
			hw = w >> 1;
			hh = h >> 1;
			// trailing odd column or row only moves the counters
			if (col < 2 * hw && row < 2 * hh) begin
				if (col % 2 == 0) begin
					pair = s;
				end else begin
					sum = pair + s;
					bx  = col / 2;
					by  = row / 2;
					if (row % 2 == 0) begin
						half_row_sums[bx] = sum;
					end else begin
						total = half_row_sums[bx] + sum;
						px.gray  = total[TOTAL_W-1:2];
						px.index = IDX_W'(bx * hh + by);
						px.last  = (bx + 1 == hw) && (by + 1 == hh);
						pixels_due.push_back(px);
					end
				end
			end
			// counters beyond a shrunk size wrap here as well
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", msg);
		endtask

		task check_pixel(logic [OUT_DATA_W-1:0] data, logic last);
			gray_pixel_t want;
			if (pixels_due.size() == 0) begin
				report($sformatf("unexpected pixel, tdata %h tlast %b", data, last));
				return;
			end
			want = pixels_due.pop_front();
			if (data[SAMPLE_W-1:0] !== want.gray)
				report($sformatf("pixel %0d: gray %0d, expected %0d",
					want.index, data[SAMPLE_W-1:0], want.gray));
			if (data[SAMPLE_W +: IDX_W] !== want.index)
				report($sformatf("pixel index %0d, expected %0d",
					data[SAMPLE_W +: IDX_W], want.index));
			if (last !== want.last)
				report($sformatf("pixel %0d: frame last %b, expected %b",
					want.index, last, want.last));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [SIZE_W-1:0]     cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata = '0;   // [7:0] raw_sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [7:0] gray_value, [27:8] pixel_index, zeros
	logic                  m_axis_tlast;        // frame_last

	binning_scoreboard sb;
	int                send_idle = 9;
	int                recv_idle = 71;
	int unsigned       cycles = 0;

	bayer_bin2x2_gray_transpose_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** bayer_bin2x2_gray_transpose_unit: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pixel(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	function logic [SAMPLE_W-1:0] random_byte();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom_range(255));
		endcase
	endfunction

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task set_frame(input int unsigned w, input int unsigned h);
		write_reg(REG_FRAME_WIDTH, w[SIZE_W-1:0]);
		write_reg(REG_FRAME_HEIGHT, h[SIZE_W-1:0]);
	endtask

	task send_sample(input logic [SAMPLE_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		sb.bin_sample(v);
	endtask

	task send_random(input int unsigned n);
		repeat (n) send_sample(random_byte());
	endtask

	// drain, then allow for bytes still in the pipe that yield no pixel
	task settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pixels_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned n, fs, w, h, sel, rnd_items;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width 0 and height 1 both act as 2: one pixel per frame
		set_frame(0, 1);
		repeat (4) send_sample(8'hFF);
		send_sample(8'h00);
		send_sample(8'h00);
		send_sample(8'h00);
		send_sample(8'h03);
		settle();

		// odd trailing column and row are dropped
		set_frame(5, 3);
		repeat (15) send_sample(random_byte());
		settle();

		// oversized height clamps to the maximum: index steps by 1024 per block
		// column; the even row also fills every line store entry used below
		set_frame(64, 4095);
		send_random(128);
		settle();

		rnd_items = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			if (rnd_items >= 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (rnd_items >= RANDOM_ITEMS / 3) begin
				send_idle = 71;
				recv_idle = 9;
			end
			sel = $urandom_range(39);
			if (sel == 0) begin
				w = $urandom_range(15, 64);
				h = $urandom_range(0, 3);
			end else if (sel == 1) begin
				w = $urandom_range(0, 3);
				h = $urandom_range(2040, 4095);
			end else begin
				w = $urandom_range(0, 14);
				h = $urandom_range(0, 14);
			end
			set_frame(w, h);
			fs = sb.clamp_size(w, MAX_WIDTH) * sb.clamp_size(h, MAX_HEIGHT);
			// mostly whole frames; now and then break off mid-frame;
			// tall frames are always broken off
			if (sel == 1)
				n = $urandom_range(1, 64);
			else if ($urandom_range(3) == 0)
				n = $urandom_range(1, sb.frame_left() + 8);
			else if (sel == 0)
				n = sb.frame_left();
			else
				n = sb.frame_left() + $urandom_range(0, 2) * fs;
			send_random(n);
			rnd_items += n;
			settle();
		end

		if (sb.errors == 0)
			$display("** bayer_bin2x2_gray_transpose_unit: PASSED **");
		else
			$display("** bayer_bin2x2_gray_transpose_unit: FAILED **");
		$finish;
	end

endmodule
